// ===== src/efr_pkg.sv =====
// Shared types and constants for the escaped frame receiver.
package efr_pkg;

    localparam int BYTE_W      = 8;
    localparam int NUM_CELLS   = 8;
    localparam int COUNT_W     = 4;
    localparam int CFG_IDX_W   = 2;

    localparam logic [COUNT_W-1:0] COUNT_FULL = 4'd8;
    localparam logic [COUNT_W-1:0] COUNT_DONE = 4'd9;

    // register indexes on the config port
    localparam logic [CFG_IDX_W-1:0] CFG_START  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FINISH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ESCAPE = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_XOR    = 2'd3;

    // reset values of the config registers
    localparam logic [BYTE_W-1:0] START_RST  = 8'd126;
    localparam logic [BYTE_W-1:0] FINISH_RST = 8'd127;
    localparam logic [BYTE_W-1:0] ESCAPE_RST = 8'd125;
    localparam logic [BYTE_W-1:0] XOR_RST    = 8'd32;

    typedef struct packed {
        logic [BYTE_W-1:0] start_code;
        logic [BYTE_W-1:0] finish_code;
        logic [BYTE_W-1:0] escape_code;
        logic [BYTE_W-1:0] escape_xor;
    } efr_cfg_t;

    // per-beat decision from the controller to the cell row
    typedef struct packed {
        logic              shift;     // push byte_val into the row
        logic [BYTE_W-1:0] byte_val;  // unescaped payload byte
        logic              emit;      // frame complete, row holds payload
    } efr_ctl_t;

endpackage

// ===== src/efr_cell.sv =====
// One byte cell of the payload shift row.
module efr_cell
(
    input  logic                       clk,
    input  logic                       shift,
    input  logic [efr_pkg::BYTE_W-1:0] d_in,
    output logic [efr_pkg::BYTE_W-1:0] q
);

    logic [efr_pkg::BYTE_W-1:0] data_reg;
    logic [efr_pkg::BYTE_W-1:0] data_next;

    always_comb
    begin
        data_next = shift ? d_in : data_reg;
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign q = data_reg;

endmodule

// ===== src/efr_ctrl.sv =====
// Byte classifier, payload count and escape tracking.
module efr_ctrl
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       beat,
    input  logic [efr_pkg::BYTE_W-1:0] rx_byte,
    input  efr_pkg::efr_cfg_t          cfg,
    output efr_pkg::efr_ctl_t          ctl
);

    logic [efr_pkg::COUNT_W-1:0] count_reg;
    logic [efr_pkg::COUNT_W-1:0] count_next;
    logic                        esc_reg;
    logic                        esc_next;
    logic                        is_start;
    logic                        is_finish;
    logic                        is_escape;
    logic                        room;

    always_comb
    begin
        is_start   = (rx_byte == cfg.start_code);
        is_finish  = (rx_byte == cfg.finish_code);
        is_escape  = (rx_byte == cfg.escape_code);
        room       = (count_reg < efr_pkg::COUNT_FULL);
        count_next = count_reg;
        esc_next   = esc_reg;
        ctl.shift  = 1'b0;
        ctl.emit   = 1'b0;
        ctl.byte_val = esc_reg ? (rx_byte ^ cfg.escape_xor) : rx_byte;
        if (beat)
        begin
            // priority: start, finish, escape, payload
            if (is_start)
            begin
                count_next = '0;
                esc_next   = 1'b0;
            end
            else if (is_finish)
            begin
                if (count_reg == efr_pkg::COUNT_FULL)
                begin
                    ctl.emit   = 1'b1;
                    count_next = efr_pkg::COUNT_DONE;
                end
            end
            else if (room)
            begin
                if (is_escape)
                begin
                    esc_next = 1'b1;
                end
                else
                begin
                    ctl.shift  = 1'b1;
                    esc_next   = 1'b0;
                    count_next = count_reg + 4'd1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            esc_reg   <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            esc_reg   <= esc_next;
        end
    end

endmodule

// ===== src/escaped_frame_receiver.sv =====
// Top level of the escaped frame receiver: config, cell row and output register.
// Usage:
//   s_axis: one received link byte per beat in tdata[7:0]. A start byte opens a
//   frame, an escape byte masks the next byte with escape_xor, other bytes fill
//   an eight-byte payload, and a finish byte after exactly eight payload bytes
//   produces one result beat on m_axis.
//   m_axis: tdata[31:0] address_word (payload bytes 0..3, byte 0 in bits 31:24),
//   tdata[63:32] data_word (payload bytes 4..7, byte 4 most significant).
//   cfg: index 0 start code, 1 finish code, 2 escape code, 3 escape mask;
//   always ready, write only while the stream is idle.
// The result is registered and appears in the cycle after the finish beat.
// Throughput: one byte per cycle while s_axis_tready is high; the controller
// decides each byte combinationally; payload bytes enter the eight-cell row.
// Reset: count and escape flag clear, codes return to 126/127/125/32, the
// output register empties. Payload cells are not reset.
// Stall: while the result sits unaccepted, s_axis_tready follows m_axis_tready,
// so a new byte is still taken in the same cycle the result leaves.
module escaped_frame_receiver
(
    input  logic        clk,
    input  logic        rst_n,
    // stream in
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    // stream out
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // [31:0] address_word, [63:32] data_word
    // config writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data
);

    efr_pkg::efr_cfg_t cfg_reg;
    efr_pkg::efr_cfg_t cfg_next;
    efr_pkg::efr_ctl_t ctl;

    logic [efr_pkg::BYTE_W-1:0] row [efr_pkg::NUM_CELLS];

    logic        m_valid_reg;
    logic        m_valid_next;
    logic [63:0] m_data_reg;
    logic [63:0] m_data_next;
    logic        s_beat;
    logic        cfg_beat;

    // config port: always ready
    assign cfg_ready = 1'b1;
    assign cfg_beat  = cfg_valid && cfg_ready;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_beat)
        begin
            case (cfg_index)
                efr_pkg::CFG_START:  cfg_next.start_code  = cfg_data;
                efr_pkg::CFG_FINISH: cfg_next.finish_code = cfg_data;
                efr_pkg::CFG_ESCAPE: cfg_next.escape_code = cfg_data;
                efr_pkg::CFG_XOR:    cfg_next.escape_xor  = cfg_data;
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_code  <= efr_pkg::START_RST;
            cfg_reg.finish_code <= efr_pkg::FINISH_RST;
            cfg_reg.escape_code <= efr_pkg::ESCAPE_RST;
            cfg_reg.escape_xor  <= efr_pkg::XOR_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // input side: take a byte whenever the output slot is free or draining
    assign s_axis_tready = !m_valid_reg || m_axis_tready;
    assign s_beat        = s_axis_tvalid && s_axis_tready;

    efr_ctrl u_ctrl
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .beat    (s_beat),
        .rx_byte (s_axis_tdata),
        .cfg     (cfg_reg),
        .ctl     (ctl)
    );

    // payload row: new bytes enter the top cell and move down one cell per
    // payload beat, so after eight beats cell 0 holds the first byte
    genvar gi;
    generate
        for (gi = 0; gi < efr_pkg::NUM_CELLS; gi++)
        begin : g_cell
            if (gi == efr_pkg::NUM_CELLS - 1)
            begin : g_top
                efr_cell u_cell
                (
                    .clk   (clk),
                    .shift (ctl.shift),
                    .d_in  (ctl.byte_val),
                    .q     (row[gi])
                );
            end
            else
            begin : g_mid
                efr_cell u_cell
                (
                    .clk   (clk),
                    .shift (ctl.shift),
                    .d_in  (row[gi+1]),
                    .q     (row[gi])
                );
            end
        end
    endgenerate

    // output register
    always_comb
    begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (m_valid_reg && m_axis_tready)
        begin
            m_valid_next = 1'b0;
        end
        if (ctl.emit)
        begin
            m_valid_next = 1'b1;
            m_data_next  = {row[4], row[5], row[6], row[7],
                            row[0], row[1], row[2], row[3]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else
        begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_data_reg <= m_data_next;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

    // checks
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_valid_reg |-> s_axis_tready)
        else $error("input stalled with empty output register");

    a_emit_not_shift: assert property (@(posedge clk) disable iff (!rst_n)
        !(ctl.emit && ctl.shift))
        else $error("result and payload shift in the same beat");

    a_emit_shows: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.emit |=> m_axis_tvalid)
        else $error("completed frame did not reach the output");

    a_emit_on_beat: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.emit || ctl.shift) |-> s_beat)
        else $error("cell row acted without an input beat");

endmodule
